>>> hdl/sile_pkg.sv
// ----------------------------------------------------------------------------
// sile_pkg: shared constants and types for the sorted ID list engine
// Status codes, request kinds, sizing defaults and the sequencer states.
// ----------------------------------------------------------------------------
package sile_pkg;

    localparam int DEPTH_DEF   = 1024;
    localparam int MAX_RUN_DEF = 16;

    localparam int KIND_W   = 2;
    localparam int ID_W     = 32;
    localparam int RUN_W    = 5;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 11;
    localparam int COUNT_W  = 10;

    localparam int S_TDATA_W = 40;  // id, run_length, zero fill
    localparam int M_TDATA_W = 56;  // position, found_id, entry_count, zero fill

    typedef enum logic [KIND_W-1:0] {
        KIND_SEARCH = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_TAKE   = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        FSM_IDLE,
        FSM_BS_REQ,
        FSM_BS_CMP,
        FSM_HIT_CMP,
        FSM_SC_LO,
        FSM_SC_HI,
        FSM_SC_CMP,
        FSM_MV_RD,
        FSM_MV_WR,
        FSM_FIN,
        FSM_DONE
    } fsm_t;

endpackage

>>> hdl/sile_ram.sv
// ----------------------------------------------------------------------------
// sile_ram: generic single-port-write, single-port-read synchronous RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module sile_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/sorted_id_list_engine_core.sv
// ----------------------------------------------------------------------------
// sorted_id_list_engine_core: sorted ID list held in one RAM
// Keeps distinct IDs in descending order and serves search, insert, remove
// and take-run requests with a read-modify-write sequencer around the RAM.
//
//   channel | ports                | fields (lowest bit up)
//   --------+----------------------+-----------------------------------------
//   request | s_tvalid/tready/...  | tuser: kind; tdata: id, run_length
//   result  | m_tvalid/tready/...  | tuser: status; tdata: position,
//           |                      |        found_id, entry_count
//
// Search runs a binary search step by step on the RAM; insert and remove then move
// each entry behind the position by one place. Take tries one tail position after
// another and, when a run is found, moves the entries behind it; a rejected take
// goes straight to its result. The single RAM read port sets this pace.
// One request is in the block at a time; the result register lets the next
// request in while a result still waits. Reset empties the list at once.
// ----------------------------------------------------------------------------
module sorted_id_list_engine_core #(
    parameter int DEPTH   = sile_pkg::DEPTH_DEF,
    parameter int MAX_RUN = sile_pkg::MAX_RUN_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [sile_pkg::S_TDATA_W-1:0] s_tdata,   // id, run_length
    input  logic [sile_pkg::KIND_W-1:0]    s_tuser,   // kind
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [sile_pkg::M_TDATA_W-1:0] m_tdata,   // position, found_id, entry_count
    output logic [sile_pkg::STATUS_W-1:0]  m_tuser    // status
);

    localparam int AW = $clog2(DEPTH);
    localparam int PW = AW + 1;

    sile_pkg::fsm_t state_reg, state_next;

    logic [AW-1:0]                 lo_reg, lo_next, hi_reg, hi_next;
    logic [AW-1:0]                 held_reg, held_next;
    logic [AW-1:0]                 p_reg, p_next;
    logic [AW-1:0]                 src_reg, src_next, dst_reg, dst_next;
    logic [AW-1:0]                 cnt_reg, cnt_next;
    logic                          down_reg, down_next;
    sile_pkg::kind_t               kind_reg, kind_next;
    logic [sile_pkg::ID_W-1:0]     key_reg, key_next;
    logic [sile_pkg::RUN_W-1:0]    n_reg, n_next;
    logic [sile_pkg::ID_W-1:0]     low_reg, low_next;
    sile_pkg::status_t             res_status_reg, res_status_next;
    logic [PW-1:0]                 res_pos_reg, res_pos_next;
    logic [sile_pkg::ID_W-1:0]     res_found_reg, res_found_next;

    logic                          m_valid_reg, m_valid_next;
    logic [sile_pkg::M_TDATA_W-1:0] m_data_reg, m_data_next;
    sile_pkg::status_t             m_status_reg, m_status_next;

    logic                          ram_wr_en;
    logic [AW-1:0]                 ram_wr_addr, ram_rd_addr;
    logic [sile_pkg::ID_W-1:0]     ram_wr_data, ram_rd_data;

    logic                          s_fire, run_ok, hit;
    logic [AW-1:0]                 mid;

    sile_ram #(.WIDTH(sile_pkg::ID_W), .DEPTH(DEPTH)) u_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign s_tready = (state_reg == sile_pkg::FSM_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign run_ok   = (32'(s_tdata[36:32]) >= 32'd1) && (32'(s_tdata[36:32]) <= MAX_RUN) &&
                      (32'(held_reg) >= 32'(s_tdata[36:32]));
    assign mid      = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign hit      = (lo_reg < held_reg) && (ram_rd_data == key_reg);

    always_comb begin
        state_next      = state_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        held_next       = held_reg;
        p_next          = p_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        cnt_next        = cnt_reg;
        down_next       = down_reg;
        kind_next       = kind_reg;
        key_next        = key_reg;
        n_next          = n_reg;
        low_next        = low_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        res_found_next  = res_found_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        m_status_next   = m_status_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = dst_reg;
        ram_wr_data     = ram_rd_data;
        ram_rd_addr     = src_reg;

        case (state_reg)
            sile_pkg::FSM_IDLE: begin
                if (s_fire) begin
                    kind_next       = sile_pkg::kind_t'(s_tuser);
                    key_next        = s_tdata[31:0];
                    n_next          = s_tdata[36:32];
                    res_found_next  = s_tdata[31:0];
                    res_status_next = sile_pkg::ST_NOT_FOUND;
                    res_pos_next    = '0;
                    lo_next         = '0;
                    hi_next         = held_reg;
                    p_next          = held_reg;
                    if (s_tuser != sile_pkg::KIND_TAKE) begin
                        state_next = sile_pkg::FSM_BS_REQ;
                    end else if (run_ok) begin
                        state_next = sile_pkg::FSM_SC_LO;
                    end else begin
                        state_next = sile_pkg::FSM_DONE;
                    end
                end
            end
            sile_pkg::FSM_BS_REQ: begin
                if (lo_reg < hi_reg) begin
                    ram_rd_addr = mid;
                    state_next  = sile_pkg::FSM_BS_CMP;
                end else begin
                    ram_rd_addr = lo_reg;
                    state_next  = sile_pkg::FSM_HIT_CMP;
                end
            end
            sile_pkg::FSM_BS_CMP: begin
                if (ram_rd_data > key_reg) begin
                    lo_next = mid + AW'(1);
                end else begin
                    hi_next = mid;
                end
                state_next = sile_pkg::FSM_BS_REQ;
            end
            sile_pkg::FSM_HIT_CMP: begin
                res_pos_next = PW'(lo_reg) + PW'(1);
                state_next   = sile_pkg::FSM_DONE;
                case (kind_reg)
                    sile_pkg::KIND_SEARCH: begin
                        res_status_next = hit ? sile_pkg::ST_OK : sile_pkg::ST_NOT_FOUND;
                    end
                    sile_pkg::KIND_INSERT: begin
                        if (hit) begin
                            res_status_next = sile_pkg::ST_DUPLICATE;
                        end else if (32'(held_reg) >= DEPTH - 1) begin
                            res_status_next = sile_pkg::ST_FULL;
                        end else begin
                            res_status_next = sile_pkg::ST_OK;
                            src_next   = held_reg - AW'(1);
                            dst_next   = held_reg;
                            cnt_next   = held_reg - lo_reg;
                            down_next  = 1'b1;
                            state_next = sile_pkg::FSM_MV_RD;
                        end
                    end
                    sile_pkg::KIND_REMOVE: begin
                        if (hit) begin
                            res_status_next = sile_pkg::ST_OK;
                            src_next   = lo_reg + AW'(1);
                            dst_next   = lo_reg;
                            cnt_next   = held_reg - lo_reg - AW'(1);
                            down_next  = 1'b0;
                            state_next = sile_pkg::FSM_MV_RD;
                        end else begin
                            res_status_next = sile_pkg::ST_NOT_FOUND;
                        end
                    end
                    default: begin
                        res_status_next = sile_pkg::ST_NOT_FOUND;
                    end
                endcase
            end
            sile_pkg::FSM_SC_LO: begin
                ram_rd_addr = p_reg - AW'(1);
                state_next  = sile_pkg::FSM_SC_HI;
            end
            sile_pkg::FSM_SC_HI: begin
                low_next    = ram_rd_data;
                ram_rd_addr = p_reg - AW'(n_reg);
                state_next  = sile_pkg::FSM_SC_CMP;
            end
            sile_pkg::FSM_SC_CMP: begin
                // A run is found when the top entry exceeds the low one by n-1.
                if ({1'b0, ram_rd_data} ==
                    {1'b0, low_reg} + 33'(n_reg) - 33'd1) begin
                    res_status_next = sile_pkg::ST_OK;
                    res_found_next  = low_reg;
                    res_pos_next    = PW'(p_reg);
                    src_next   = p_reg;
                    dst_next   = p_reg - AW'(n_reg);
                    cnt_next   = held_reg - p_reg;
                    down_next  = 1'b0;
                    state_next = sile_pkg::FSM_MV_RD;
                end else if (32'(p_reg) == 32'(n_reg)) begin
                    state_next = sile_pkg::FSM_DONE;
                end else begin
                    p_next     = p_reg - AW'(1);
                    state_next = sile_pkg::FSM_SC_LO;
                end
            end
            sile_pkg::FSM_MV_RD: begin
                if (cnt_reg == '0) begin
                    state_next = sile_pkg::FSM_FIN;
                end else begin
                    state_next = sile_pkg::FSM_MV_WR;
                end
            end
            sile_pkg::FSM_MV_WR: begin
                ram_wr_en = 1'b1;
                cnt_next  = cnt_reg - AW'(1);
                if (down_reg) begin
                    src_next = src_reg - AW'(1);
                    dst_next = dst_reg - AW'(1);
                end else begin
                    src_next = src_reg + AW'(1);
                    dst_next = dst_reg + AW'(1);
                end
                state_next = sile_pkg::FSM_MV_RD;
            end
            sile_pkg::FSM_FIN: begin
                state_next = sile_pkg::FSM_DONE;
                case (kind_reg)
                    sile_pkg::KIND_INSERT: begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = lo_reg;
                        ram_wr_data = key_reg;
                        held_next   = held_reg + AW'(1);
                    end
                    sile_pkg::KIND_REMOVE: begin
                        held_next = held_reg - AW'(1);
                    end
                    sile_pkg::KIND_TAKE: begin
                        held_next = held_reg - AW'(n_reg);
                    end
                    default: begin
                        held_next = held_reg;
                    end
                endcase
            end
            sile_pkg::FSM_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_data_next   = {3'b000, sile_pkg::COUNT_W'(held_reg), res_found_reg,
                                     sile_pkg::POS_W'(res_pos_reg)};
                    state_next    = sile_pkg::FSM_IDLE;
                end
            end
            default: begin
                state_next = sile_pkg::FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sile_pkg::FSM_IDLE;
            held_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            held_reg    <= held_next;
            m_valid_reg <= m_valid_next;
        end
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        p_reg          <= p_next;
        src_reg        <= src_next;
        dst_reg        <= dst_next;
        cnt_reg        <= cnt_next;
        down_reg       <= down_next;
        kind_reg       <= kind_next;
        key_reg        <= key_next;
        n_reg          <= n_next;
        low_reg        <= low_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        res_found_reg  <= res_found_next;
        m_data_reg     <= m_data_next;
        m_status_reg   <= m_status_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;

endmodule

>>> hdl/sile_checker.sv
// ----------------------------------------------------------------------------
// sile_checker: port-level checks for the sorted ID list engine
// Watches the request and result beats and is bound to the top level.
// ----------------------------------------------------------------------------
module sile_checker #(
    parameter int DEPTH = sile_pkg::DEPTH_DEF
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [sile_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [sile_pkg::STATUS_W-1:0]  m_tuser
);

    // A stalled result beat keeps its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // Only one request is in the block at a time.
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while another is in progress");

    // A full report comes only with the list at capacity.
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == sile_pkg::ST_FULL |-> m_tdata[52:43] == 10'(DEPTH - 1))
        else $error("list full reported below capacity");

    // A successful request always reports a position of one or more.
    a_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == sile_pkg::ST_OK |-> m_tdata[10:0] != 11'd0)
        else $error("successful request with position zero");

endmodule

bind sorted_id_list_engine_core sile_checker #(.DEPTH(DEPTH)) u_sile_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> sim/sile_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sile_scoreboard: result checker for the sorted ID list engine
// Watches both channels, keeps its own sorted list to work out each result
// and compares every result beat, field by field, with the oldest one due.
// ----------------------------------------------------------------------------
module sile_scoreboard (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [sile_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [sile_pkg::KIND_W-1:0]    s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [sile_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic [sile_pkg::STATUS_W-1:0]  m_tuser,
    output int                             fail_count,
    output int                             pending
);

    localparam int DEPTH = sile_pkg::DEPTH_DEF;

    typedef struct packed {
        sile_pkg::status_t            status;
        logic [sile_pkg::POS_W-1:0]   position;
        logic [sile_pkg::ID_W-1:0]    found_id;
        logic [sile_pkg::COUNT_W-1:0] entry_count;
    } list_result_t;

    logic [sile_pkg::ID_W-1:0] list_ids [DEPTH];   // descending, 0 .. list_len-1 valid
    int                        list_len;
    list_result_t              results_due [$];

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    function automatic list_result_t apply_request(sile_pkg::kind_t kind,
                                                   logic [sile_pkg::ID_W-1:0] key,
                                                   int unsigned n);
        list_result_t r;
        int           at;
        bit           hit;
        logic [32:0]  low;
        logic [32:0]  top;
        r.status   = sile_pkg::ST_NOT_FOUND;
        r.position = '0;
        r.found_id = key;
        if (kind != sile_pkg::KIND_TAKE) begin
            at = 0;
            while (at < list_len && list_ids[at] > key) at++;
            hit = (at < list_len) && (list_ids[at] == key);
            r.position = sile_pkg::POS_W'(at + 1);
            case (kind)
                sile_pkg::KIND_SEARCH: begin
                    r.status = hit ? sile_pkg::ST_OK : sile_pkg::ST_NOT_FOUND;
                end
                sile_pkg::KIND_INSERT: begin
                    if (hit) begin
                        r.status = sile_pkg::ST_DUPLICATE;
                    end else if (list_len >= DEPTH - 1) begin
                        r.status = sile_pkg::ST_FULL;
                    end else begin
                        for (int i = list_len; i > at; i--) list_ids[i] = list_ids[i-1];
                        list_ids[at] = key;
                        list_len++;
                        r.status = sile_pkg::ST_OK;
                    end
                end
                default: begin
                    if (hit) begin
                        for (int i = at; i < list_len - 1; i++) list_ids[i] = list_ids[i+1];
                        list_len--;
                        r.status = sile_pkg::ST_OK;
                    end
                end
            endcase
        end else if (n >= 1 && n <= sile_pkg::MAX_RUN_DEF && list_len >= n) begin
            // The run nearest the tail wins.
            for (int p = list_len; p >= n; p--) begin
                low = {1'b0, list_ids[p-1]};
                top = {1'b0, list_ids[p-n]};
                if (top == low + 33'(n - 1)) begin
                    r.found_id = low[31:0];
                    r.position = sile_pkg::POS_W'(p);
                    r.status   = sile_pkg::ST_OK;
                    for (int i = p; i < list_len; i++) list_ids[i-n] = list_ids[i];
                    list_len -= int'(n);
                    break;
                end
            end
        end
        r.entry_count = sile_pkg::COUNT_W'(list_len);
        return r;
    endfunction

    assign pending = results_due.size();

    always @(posedge aclk) begin
        list_result_t want;
        if (!aresetn) begin
            fail_count = 0;
            list_len   = 0;
            results_due.delete();
        end else begin
            if (s_tvalid && s_tready)
                results_due.push_back(apply_request(sile_pkg::kind_t'(s_tuser),
                                                    s_tdata[31:0],
                                                    32'(s_tdata[36:32])));
            if (m_tvalid && m_tready) begin
                if (results_due.size() == 0) begin
                    report("unexpected result beat", 64'({m_tuser, m_tdata}), 64'd0);
                end else begin
                    want = results_due.pop_front();
                    if (m_tuser != want.status)
                        report("status", 64'(m_tuser), 64'(want.status));
                    if (m_tdata[10:0] != want.position)
                        report("position", 64'(m_tdata[10:0]), 64'(want.position));
                    if (m_tdata[42:11] != want.found_id)
                        report("found_id", 64'(m_tdata[42:11]), 64'(want.found_id));
                    if (m_tdata[52:43] != want.entry_count)
                        report("entry_count", 64'(m_tdata[52:43]),
                               64'(want.entry_count));
                    if (m_tdata[55:53] != 3'd0)
                        report("tdata fill", 64'(m_tdata[55:53]), 64'd0);
                end
            end
        end
    end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus for the sorted ID list engine
// Directed requests on the corners, a block of consecutive IDs built and taken
// again, then random requests mostly on a small pool of IDs, with random idling
// on both channels and one long stall of the result channel.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CYCLE_LIMIT = 3000000;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [sile_pkg::S_TDATA_W-1:0] s_tdata;
    logic [sile_pkg::KIND_W-1:0]    s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [sile_pkg::M_TDATA_W-1:0] m_tdata;
    logic [sile_pkg::STATUS_W-1:0]  m_tuser;
    int                             fail_count;
    int                             pending;
    int                             cycles;
    bit                             no_idle;
    bit                             hold_req;
    logic                           hold_off;

    sorted_id_list_engine_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    sile_scoreboard u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("sorted_id_list_engine_core verification failed");
                $finish;
            end
        end
    end

    // Result channel readiness, with one long hold-off on request.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            m_tready <= !hold_off && (no_idle || $urandom_range(99) >= 14);
        end
    end

    initial begin
        hold_off = 1'b0;
        wait (hold_req);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (300) @(posedge aclk);
        hold_off <= 1'b0;
    end

    task automatic send(input sile_pkg::kind_t kind, input logic [sile_pkg::ID_W-1:0] id,
                        input logic [4:0] n);
        while (!no_idle && $urandom_range(99) < 14) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {3'd0, n, id};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    function automatic logic [sile_pkg::ID_W-1:0] pick_id();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 45) return sile_pkg::ID_W'($urandom_range(47));
        if (r < 90) return 32'hFFFF_FFD0 + sile_pkg::ID_W'($urandom_range(47));
        return $urandom;
    endfunction

    function automatic logic [4:0] pick_run();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70) return 5'($urandom_range(3, 1));
        if (r < 90) return 5'($urandom_range(16, 4));
        return 5'($urandom_range(31));
    endfunction

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = sile_pkg::KIND_SEARCH;
        no_idle  = 1'b0;
        hold_req = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Corners on an empty and a small list.
        send(sile_pkg::KIND_SEARCH, 32'd7, 5'd1);
        send(sile_pkg::KIND_REMOVE, 32'd7, 5'd1);
        send(sile_pkg::KIND_TAKE, 32'hA5A5_A5A5, 5'd1);
        send(sile_pkg::KIND_INSERT, 32'd0, 5'd0);
        send(sile_pkg::KIND_INSERT, 32'hFFFF_FFFF, 5'd31);
        send(sile_pkg::KIND_INSERT, 32'd0, 5'd1);
        // A maximal and a minimal ID next to each other are not a run.
        send(sile_pkg::KIND_TAKE, 32'd9, 5'd2);
        send(sile_pkg::KIND_INSERT, 32'd1, 5'd1);
        send(sile_pkg::KIND_INSERT, 32'd2, 5'd1);
        send(sile_pkg::KIND_INSERT, 32'd3, 5'd1);
        send(sile_pkg::KIND_SEARCH, 32'hFFFF_FFFF, 5'd1);
        send(sile_pkg::KIND_SEARCH, 32'd5, 5'd1);
        send(sile_pkg::KIND_TAKE, 32'd0, 5'd5);
        send(sile_pkg::KIND_TAKE, 32'd0, 5'd17);
        send(sile_pkg::KIND_TAKE, 32'd0, 5'd0);
        send(sile_pkg::KIND_TAKE, 32'hFFFF_FFFF, 5'd3);
        send(sile_pkg::KIND_REMOVE, 32'hFFFF_FFFF, 5'd1);
        send(sile_pkg::KIND_REMOVE, 32'd0, 5'd1);
        send(sile_pkg::KIND_SEARCH, 32'd0, 5'd1);
        drain();

        // Build a block of consecutive IDs, then take runs from the tail.
        no_idle = 1'b1;
        for (int i = 0; i < 48; i++) begin
            send(sile_pkg::KIND_INSERT, sile_pkg::ID_W'(2000 - i), 5'd1);
        end
        no_idle = 1'b0;
        send(sile_pkg::KIND_INSERT, 32'd1970, 5'd1);
        send(sile_pkg::KIND_INSERT, 32'd5000, 5'd1);
        send(sile_pkg::KIND_INSERT, 32'd10, 5'd1);
        send(sile_pkg::KIND_SEARCH, 32'd1978, 5'd1);
        for (int i = 0; i < 3; i++) send(sile_pkg::KIND_TAKE, 32'd0, 5'd16);
        send(sile_pkg::KIND_TAKE, 32'd0, 5'd15);
        send(sile_pkg::KIND_TAKE, 32'd0, 5'd1);
        send(sile_pkg::KIND_TAKE, 32'd0, 5'd1);
        drain();

        // Random traffic; the result channel stalls for a while part way in.
        for (int i = 0; i < 320; i++) begin
            if (i == 100) hold_req = 1'b1;
            if (i == 200) drain();
            no_idle = (i >= 250 && i < 310);
            send(sile_pkg::kind_t'($urandom_range(3)), pick_id(), pick_run());
        end
        no_idle = 1'b0;
        drain();
        repeat (200) @(posedge aclk);

        if (fail_count == 0) begin
            $display("sorted_id_list_engine_core verification clean");
        end else begin
            $display("sorted_id_list_engine_core verification failed");
        end
        $finish;
    end

endmodule
